### src/setq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setq_pkg
// Shared sizes, types, codes and the wrap-safe expiry compare for the sorted
// expiry timer queue.
// ----------------------------------------------------------------------------
package setq_pkg;

   localparam int TIMER_SLOTS = 16;
   localparam int TICK_BITS   = 32;
   localparam int ID_BITS     = 4;
   localparam int NUM_IDS     = 16;
   localparam int EXPIRY_BITS = 32;
   localparam int MAX_RES     = 16;
   localparam int LEN_BITS    = $clog2(TIMER_SLOTS + 1);
   localparam int SLOT_BITS   = $clog2(TIMER_SLOTS);
   localparam int RES_BITS    = $clog2(MAX_RES + 1);

   typedef logic [TICK_BITS-1:0]   tick_type;
   typedef logic [ID_BITS-1:0]     id_type;
   typedef logic [EXPIRY_BITS-1:0] expiry_type;

   typedef enum logic [1:0] {
      KIND_ADD    = 2'd0,
      KIND_DELETE = 2'd1,
      KIND_TICK   = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_ADDED       = 3'd0,
      ST_FULL        = 3'd1,
      ST_PENDING     = 3'd2,
      ST_DELETED     = 3'd3,
      ST_NOT_PENDING = 3'd4,
      ST_EXPIRED     = 3'd5,
      ST_TICK_NONE   = 3'd6
   } status_type;

   typedef enum logic {
      TOK_INSERT = 1'b0,
      TOK_DELETE = 1'b1
   } tok_op_type;

   typedef struct packed {
      logic       active;
      tok_op_type op;
      logic       shifting;
      id_type     id;
      tick_type   expiry;
   } token_type;

   typedef struct packed {
      id_type   id;
      tick_type expiry;
   } entry_type;

   // a is before b when (a - b) mod 2^TICK_BITS is negative
   function automatic logic is_before(tick_type a, tick_type b);
      tick_type d;
      d = a - b;
      return d[TICK_BITS-1];
   endfunction

   function automatic tick_type to_tick(expiry_type e);
      logic [63:0] w;
      w = 64'(e);
      return w[TICK_BITS-1:0];
   endfunction

   function automatic expiry_type to_now(tick_type t);
      logic [63:0] w;
      w = 64'(t);
      return w[EXPIRY_BITS-1:0];
   endfunction

endpackage

### src/setq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setq_if
// Request and response channels of the sorted expiry timer queue.
// ----------------------------------------------------------------------------
interface setq_req_if;
   logic                   valid;
   logic                   ready;
   logic [1:0]             kind;
   setq_pkg::id_type       timer_id;
   setq_pkg::expiry_type   expiry;

   modport source (output valid, kind, timer_id, expiry, input ready);
   modport sink   (input valid, kind, timer_id, expiry, output ready);
endinterface

interface setq_rsp_if;
   logic                   valid;
   logic                   ready;
   setq_pkg::status_type   status;
   setq_pkg::id_type       fired_id;
   setq_pkg::expiry_type   now_ticks;
   logic                   last;

   modport source (output valid, status, fired_id, now_ticks, last, input ready);
   modport sink   (input valid, status, fired_id, now_ticks, last, output ready);
endinterface

### src/sorted_expiry_timer_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_expiry_timer_queue_core
// Timer queue kept sorted by wrap-safe expiry in a row of slot cells.
//
//   channel   dir   handshake          payload
//   req_ch    in    valid / ready      kind, timer_id, expiry
//   rsp_ch    out   valid / ready      status, fired_id, now_ticks, last
//
// An accepted add or delete sends a token down the row, one cell a cycle, and
// its result follows when the walk ends; rejected ones skip the walk. A tick
// gives one result a cycle while the output register is free; each expiry
// shifts the whole row left one slot. Reset clears tick count, queue length
// and pending flags. A stalled result holds in the output register; the next
// item is accepted meanwhile and its result waits until the register frees.
// ----------------------------------------------------------------------------
module sorted_expiry_timer_queue_core (
   input  logic        clock,
   input  logic        reset,
   setq_req_if.sink    req_ch,
   setq_rsp_if.source  rsp_ch
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_TICK,
      S_EMIT
   } state_type;

   state_type                           state_ff, state_in;
   setq_pkg::tick_type                  tick_ff, tick_in;
   logic [setq_pkg::LEN_BITS-1:0]       len_ff, len_in;
   logic [setq_pkg::NUM_IDS-1:0]        pend_ff, pend_in;
   logic [setq_pkg::SLOT_BITS-1:0]      walk_ff, walk_in;
   logic [setq_pkg::RES_BITS-1:0]       pops_ff, pops_in;
   setq_pkg::token_type                 launch_ff, launch_in;
   setq_pkg::status_type                hold_status_ff, hold_status_in;
   setq_pkg::id_type                    hold_id_ff, hold_id_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   setq_pkg::status_type                rsp_status_ff, rsp_status_in;
   setq_pkg::id_type                    rsp_id_ff, rsp_id_in;
   setq_pkg::expiry_type                rsp_now_ff, rsp_now_in;
   logic                                rsp_last_ff, rsp_last_in;

   setq_pkg::entry_type                 ent [setq_pkg::TIMER_SLOTS];
   setq_pkg::token_type                 tok [setq_pkg::TIMER_SLOTS];
   logic [setq_pkg::TIMER_SLOTS-1:0]    occ;
   logic                                pop;
   logic                                accept;
   logic                                out_free;
   logic                                due0;
   logic                                due1;
   logic                                more;

   genvar gi;
   generate
      for (gi = 0; gi < setq_pkg::TIMER_SLOTS; gi++) begin : g_cell
         assign occ[gi] = setq_pkg::LEN_BITS'(gi) < len_ff;
         if (gi == 0) begin : g_first
            setq_cell u_cell (
               .clock      (clock),
               .reset      (reset),
               .occupied   (occ[gi]),
               .pop        (pop),
               .tok_left   (launch_ff),
               .next_entry (ent[gi+1]),
               .entry_out  (ent[gi]),
               .tok_right  (tok[gi])
            );
         end else if (gi == setq_pkg::TIMER_SLOTS - 1) begin : g_last
            setq_cell u_cell (
               .clock      (clock),
               .reset      (reset),
               .occupied   (occ[gi]),
               .pop        (pop),
               .tok_left   (tok[gi-1]),
               .next_entry (ent[gi]),
               .entry_out  (ent[gi]),
               .tok_right  (tok[gi])
            );
         end else begin : g_mid
            setq_cell u_cell (
               .clock      (clock),
               .reset      (reset),
               .occupied   (occ[gi]),
               .pop        (pop),
               .tok_left   (tok[gi-1]),
               .next_entry (ent[gi+1]),
               .entry_out  (ent[gi]),
               .tok_right  (tok[gi])
            );
         end
      end
   endgenerate

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign due0         = occ[0] && !setq_pkg::is_before(tick_ff, ent[0].expiry);
   assign due1         = occ[1] && !setq_pkg::is_before(tick_ff, ent[1].expiry);
   assign more         = ((pops_ff + setq_pkg::RES_BITS'(1)) <
                          setq_pkg::RES_BITS'(setq_pkg::MAX_RES)) && due1;

   always_comb begin
      state_in       = state_ff;
      tick_in        = tick_ff;
      len_in         = len_ff;
      pend_in        = pend_ff;
      walk_in        = walk_ff;
      pops_in        = pops_ff;
      launch_in      = launch_ff;
      launch_in.active = 1'b0;
      hold_status_in = hold_status_ff;
      hold_id_in     = hold_id_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_now_in     = rsp_now_ff;
      rsp_last_in    = rsp_last_ff;
      pop            = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_ch.kind)
                  setq_pkg::KIND_ADD: begin
                     hold_id_in = req_ch.timer_id;
                     if (len_ff == setq_pkg::LEN_BITS'(setq_pkg::TIMER_SLOTS)) begin
                        hold_status_in = setq_pkg::ST_FULL;
                        state_in       = S_EMIT;
                     end else if (pend_ff[req_ch.timer_id]) begin
                        hold_status_in = setq_pkg::ST_PENDING;
                        state_in       = S_EMIT;
                     end else begin
                        launch_in.active        = 1'b1;
                        launch_in.op            = setq_pkg::TOK_INSERT;
                        launch_in.shifting      = 1'b0;
                        launch_in.id            = req_ch.timer_id;
                        launch_in.expiry        = setq_pkg::to_tick(req_ch.expiry);
                        pend_in[req_ch.timer_id] = 1'b1;
                        hold_status_in          = setq_pkg::ST_ADDED;
                        walk_in                 = '0;
                        state_in                = S_WALK;
                     end
                  end
                  setq_pkg::KIND_DELETE: begin
                     hold_id_in = req_ch.timer_id;
                     if (!pend_ff[req_ch.timer_id]) begin
                        hold_status_in = setq_pkg::ST_NOT_PENDING;
                        state_in       = S_EMIT;
                     end else begin
                        launch_in.active        = 1'b1;
                        launch_in.op            = setq_pkg::TOK_DELETE;
                        launch_in.shifting      = 1'b0;
                        launch_in.id            = req_ch.timer_id;
                        launch_in.expiry        = '0;
                        pend_in[req_ch.timer_id] = 1'b0;
                        hold_status_in          = setq_pkg::ST_DELETED;
                        walk_in                 = '0;
                        state_in                = S_WALK;
                     end
                  end
                  setq_pkg::KIND_TICK: begin
                     tick_in  = tick_ff + setq_pkg::tick_type'(1);
                     pops_in  = '0;
                     state_in = S_TICK;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_WALK: begin
            if (walk_ff == setq_pkg::SLOT_BITS'(setq_pkg::TIMER_SLOTS - 1)) begin
               if (hold_status_ff == setq_pkg::ST_ADDED) begin
                  len_in = len_ff + setq_pkg::LEN_BITS'(1);
               end else begin
                  len_in = len_ff - setq_pkg::LEN_BITS'(1);
               end
               state_in = S_EMIT;
            end else begin
               walk_in = walk_ff + setq_pkg::SLOT_BITS'(1);
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = hold_status_ff;
               rsp_id_in     = hold_id_ff;
               rsp_now_in    = setq_pkg::to_now(tick_ff);
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_TICK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_now_in   = setq_pkg::to_now(tick_ff);
               if (due0) begin
                  rsp_status_in      = setq_pkg::ST_EXPIRED;
                  rsp_id_in          = ent[0].id;
                  rsp_last_in        = !more;
                  pop                = 1'b1;
                  len_in             = len_ff - setq_pkg::LEN_BITS'(1);
                  pend_in[ent[0].id] = 1'b0;
                  pops_in            = pops_ff + setq_pkg::RES_BITS'(1);
                  if (!more) begin
                     state_in = S_IDLE;
                  end
               end else begin
                  rsp_status_in = setq_pkg::ST_TICK_NONE;
                  rsp_id_in     = '0;
                  rsp_last_in   = 1'b1;
                  state_in      = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      hold_status_ff <= hold_status_in;
      hold_id_ff     <= hold_id_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_now_ff     <= rsp_now_in;
      rsp_last_ff    <= rsp_last_in;
      walk_ff        <= walk_in;
      pops_ff        <= pops_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         tick_ff      <= '0;
         len_ff       <= '0;
         pend_ff      <= '0;
         launch_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         len_ff       <= len_in;
         pend_ff      <= pend_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.status    = rsp_status_ff;
   assign rsp_ch.fired_id  = rsp_id_ff;
   assign rsp_ch.now_ticks = rsp_now_ff;
   assign rsp_ch.last      = rsp_last_ff;

endmodule

### src/setq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setq_cell
// One slot of the sorted row: holds a timer entry, acts on the token handed
// in from the left and passes it on to the right in the next cycle.
// ----------------------------------------------------------------------------
module setq_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 occupied,
   input  logic                 pop,
   input  setq_pkg::token_type  tok_left,
   input  setq_pkg::entry_type  next_entry,
   output setq_pkg::entry_type  entry_out,
   output setq_pkg::token_type  tok_right
);

   setq_pkg::entry_type entry_ff, entry_in;
   setq_pkg::token_type tok_ff, tok_in;

   always_comb begin
      entry_in = entry_ff;
      tok_in   = tok_left;
      if (pop) begin
         entry_in = next_entry;
      end else if (tok_left.active) begin
         case (tok_left.op)
            setq_pkg::TOK_INSERT: begin
               if (!occupied) begin
                  entry_in.id     = tok_left.id;
                  entry_in.expiry = tok_left.expiry;
                  tok_in.active   = 1'b0;
               end else if (tok_left.shifting ||
                            setq_pkg::is_before(tok_left.expiry, entry_ff.expiry)) begin
                  // take the carried timer, carry the displaced one on
                  entry_in.id     = tok_left.id;
                  entry_in.expiry = tok_left.expiry;
                  tok_in.id       = entry_ff.id;
                  tok_in.expiry   = entry_ff.expiry;
                  tok_in.shifting = 1'b1;
               end
            end
            setq_pkg::TOK_DELETE: begin
               if (tok_left.shifting || (occupied && entry_ff.id == tok_left.id)) begin
                  entry_in        = next_entry;
                  tok_in.shifting = 1'b1;
               end
            end
            default: begin
               entry_in = entry_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign entry_out = entry_ff;
   assign tok_right = tok_ff;

endmodule
